>>> rtl/selective_repeat_sender_window_macros.svh
// Assertion shorthands used by the RTL controller. All checks run on the rising
// edge of clock and are held off while reset is high.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// Same-cycle implication.
`define SRSW_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sender window check failed");

// Next-cycle implication.
`define SRSW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sender window check failed");

`endif

>>> rtl/srsw_pkg.sv
package srsw_pkg;

   // Built defaults of the top-level parameters.
   localparam int WINDOW_MAX_DEFAULT = 16;
   localparam int FRAME_BITS_DEFAULT = 16;

   // Fixed field widths.
   localparam int FRAME_W = 16;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = 16;
   localparam int WIN_W   = 5;
   localparam int NEXT_W  = 17;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [NEXT_W-1:0]  NEXT_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(4);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FRAMES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_SENT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OFFER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

   // One result item as produced by the sequencer.
   typedef struct packed {
      logic                valid;
      logic [KIND_W-1:0]   kind;
      logic [FRAME_W-1:0]  frame;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rsp_item_type;

   // Commands to the slot occupancy flags.
   typedef struct packed {
      logic clear_all;
      logic set;
      logic clr;
   } flag_cmd_type;

endpackage

>>> rtl/srsw_ram.sv
module srsw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic [ADDR_W-1:0]       rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> rtl/srsw_flags.sv
module srsw_flags
   import srsw_pkg::*;
#(
   parameter int DEPTH = WINDOW_MAX_DEFAULT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  flag_cmd_type       cmd,
   input  logic [IDX_W-1:0]   wr_idx,
   input  logic [IDX_W-1:0]   rd_idx,
   output logic               rd_full
);

   logic [DEPTH-1:0] full_ff;
   logic [DEPTH-1:0] full_in;

   // Clearing the whole window wins over a single-slot update.
   always_comb begin
      full_in = full_ff;
      if (cmd.clear_all) begin
         full_in = '0;
      end else if (cmd.set) begin
         full_in[wr_idx] = 1'b1;
      end else if (cmd.clr) begin
         full_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else begin
         full_ff <= full_in;
      end
   end

   assign rd_full = full_ff[rd_idx];

endmodule

>>> rtl/srsw_ctrl.sv
`include "selective_repeat_sender_window_macros.svh"

module srsw_ctrl
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT,
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic                   req_ack,
   input  logic [TOTAL_W-1:0]     total,
   input  logic [WIN_W-1:0]       window,
   input  logic                   emit_ok,
   output rsp_item_type           emit,
   output flag_cmd_type           flag_cmd,
   output logic [PTR_W-1:0]       flag_idx,
   output logic [PTR_W-1:0]       rd_idx,
   input  logic                   rd_full,
   output logic                   ram_we,
   output logic [PTR_W-1:0]       ram_waddr,
   output logic [FRAME_BITS-1:0]  ram_wdata,
   input  logic [FRAME_BITS-1:0]  ram_rdata
);

   localparam int WS_W  = $clog2(WINDOW_MAX + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WRAP,
      ST_ACK,
      ST_SEEK,
      ST_OFFER
   } state_type;

   state_type            state_ff;
   logic                 active_ff;
   logic                 ack_ff;
   logic [PTR_W-1:0]     ptr_ff;
   logic [PTR_W-1:0]     k_ff;
   logic [WS_W-1:0]      load_ff;
   logic [NEXT_W-1:0]    next_ff;
   logic [COUNT_W-1:0]   count_ff;

   logic [WS_W-1:0]      ws;
   logic [WS_W-1:0]      ptr_ext;
   logic [WS_W-1:0]      ptr_inc;
   logic [PTR_W-1:0]     ptr_wrap;
   logic                 ptr_ge;
   logic [PTR_W-1:0]     ptr_sub;
   logic                 load_more;
   logic                 next_lt_total;
   logic                 hit_ack;
   logic                 seek_last;
   logic [COUNT_W-1:0]   count_inc;
   logic [NEXT_W-1:0]    next_inc;
   logic                 emit_taken;
   logic                 walk_state;

   // Window size in use: zero acts as one, large values clamp to the build.
   always_comb begin
      if (window == '0) begin
         ws = WS_W'(1);
      end else if (32'(window) > WINDOW_MAX) begin
         ws = WS_W'(WINDOW_MAX);
      end else begin
         ws = WS_W'(window);
      end
   end

   // Shared pointer unit: one compare-subtract and one wrap-increment.
   assign ptr_ext  = WS_W'(ptr_ff);
   assign ptr_ge   = (ptr_ext >= ws);
   assign ptr_sub  = PTR_W'(ptr_ext - ws);
   assign ptr_inc  = ptr_ext + WS_W'(1);
   assign ptr_wrap = (ptr_inc == ws) ? '0 : PTR_W'(ptr_inc);

   assign load_more     = (load_ff < ws) && (32'(load_ff) < 32'(total));
   assign next_lt_total = (next_ff < NEXT_W'(total));
   assign hit_ack       = rd_full && ack_ff;
   assign seek_last     = (WS_W'(k_ff) == (ws - WS_W'(1)));
   assign count_inc     = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign next_inc      = (next_ff != NEXT_MAX) ? next_ff + NEXT_W'(1) : next_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_idx    = ptr_ff;

   always_comb begin
      emit       = '0;
      emit.count = count_ff;
      flag_cmd   = '0;
      flag_idx   = ptr_ff;
      ram_we     = 1'b0;
      ram_waddr  = ptr_ff;
      ram_wdata  = FRAME_BITS'(next_ff);
      case (state_ff)
         ST_IDLE: begin
            flag_cmd.clear_all = req_valid && !req_func;
         end
         ST_LOAD: begin
            if (load_more) begin
               emit.valid   = 1'b1;
               emit.kind    = KIND_SENT;
               emit.frame   = FRAME_W'(FRAME_BITS'(32'(load_ff)));
               ram_we       = emit_ok;
               ram_waddr    = PTR_W'(load_ff);
               ram_wdata    = FRAME_BITS'(32'(load_ff));
               flag_cmd.set = emit_ok;
               flag_idx     = PTR_W'(load_ff);
            end
         end
         ST_ACK: begin
            if (hit_ack) begin
               if (next_lt_total) begin
                  emit.valid = 1'b1;
                  emit.kind  = KIND_SENT;
                  emit.frame = FRAME_W'(FRAME_BITS'(next_ff));
                  ram_we     = emit_ok;
               end else begin
                  flag_cmd.clr = 1'b1;
               end
            end
         end
         ST_SEEK: begin
            if (!rd_full && seek_last) begin
               emit.valid = 1'b1;
               emit.kind  = KIND_DONE;
               emit.last  = 1'b1;
            end
         end
         ST_OFFER: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_OFFER;
            emit.frame = FRAME_W'(ram_rdata);
            emit.last  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         ack_ff    <= 1'b0;
         ptr_ff    <= '0;
         k_ff      <= '0;
         load_ff   <= '0;
         next_ff   <= '0;
         count_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (!req_func) begin
                     ptr_ff    <= '0;
                     count_ff  <= '0;
                     active_ff <= 1'b1;
                     load_ff   <= '0;
                     next_ff   <= NEXT_W'(ws);
                     state_ff  <= ST_LOAD;
                  end else if (active_ff) begin
                     count_ff <= count_inc;
                     ack_ff   <= req_ack;
                     state_ff <= ST_WRAP;
                  end
               end
            end
            ST_LOAD: begin
               if (load_more) begin
                  if (emit_ok) begin
                     load_ff <= load_ff + WS_W'(1);
                  end
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_SEEK;
               end
            end
            ST_WRAP: begin
               if (ptr_ge) begin
                  ptr_ff <= ptr_sub;
               end else begin
                  state_ff <= ST_ACK;
               end
            end
            ST_ACK: begin
               if (!(hit_ack && next_lt_total && !emit_ok)) begin
                  if (hit_ack) begin
                     next_ff <= next_inc;
                  end
                  ptr_ff   <= ptr_wrap;
                  k_ff     <= '0;
                  state_ff <= ST_SEEK;
               end
            end
            ST_SEEK: begin
               if (rd_full) begin
                  state_ff <= ST_OFFER;
               end else if (seek_last) begin
                  if (emit_ok) begin
                     active_ff <= 1'b0;
                     state_ff  <= ST_IDLE;
                  end
               end else begin
                  ptr_ff <= ptr_wrap;
                  k_ff   <= k_ff + PTR_W'(1);
               end
            end
            ST_OFFER: begin
               if (emit_ok) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A result is taken into the output register, and the pointer must lie
   // inside the window in the states that use it.
   assign emit_taken = emit.valid && emit_ok;
   assign walk_state = (state_ff == ST_ACK) || (state_ff == ST_SEEK) || (state_ff == ST_OFFER);

   `SRSW_ASSERT_NEXT(a_last_returns_idle, emit_taken && emit.last, state_ff == ST_IDLE)
   `SRSW_ASSERT_NEXT(a_done_ends_session, emit_taken && (emit.kind == KIND_DONE), !active_ff)
   `SRSW_ASSERT_IMP(a_seek_bounded, state_ff == ST_SEEK, WS_W'(k_ff) < ws)
   `SRSW_ASSERT_IMP(a_ptr_in_window, walk_state, ptr_ext < ws)
   `SRSW_ASSERT_IMP(a_offer_slot_full, state_ff == ST_OFFER, rd_full)

endmodule

>>> rtl/selective_repeat_sender_window.sv
// Sender window of a selective-repeat ARQ link. Write total_frames (register 0)
// and window_size (register 1, 0 acts as 1, values above WINDOW_MAX clamp) while
// the block is idle. A start item (req_tuser = 0) clears the window, loads
// frames 0 upward into the slots, reports each one as sent, and then offers the
// first outstanding frame, or reports done when no frame was loaded. Each
// response item (req_tuser = 1, req_tdata[0] = 1 for received, 0 for lost)
// counts one transmission; a received frame's slot is refilled with the next
// new frame, reported as sent, or emptied once all frames are used, and a lost
// frame stays in its slot for a later retry. The offer pointer then moves
// round-robin to the next occupied slot and offers its frame, or reports done
// with the transmission count when no slot is occupied. Responses outside a
// session are dropped without any result. The last result of every item
// carries rsp_tlast. One item is handled at a time. A start item passes
// through a load step per frame loaded and then the search; a response passes
// through the wrap step, which subtracts the window size while the pointer
// lies outside a shrunk window, then the acknowledge step and the search.
// The search walks the slots one per cycle through a single shared pointer
// compare and increment unit. Frame numbers come from a registered-read slot
// memory, so a slot that the search finds occupied is offered from the offer
// state that follows. Results wait in an output register, so a stalled result
// holds the sequencer only when it has another result to give.
module selective_repeat_sender_window
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Item input channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] acknowledged, [7:1] zero
   input  logic                   req_tuser,   // [0] func
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,   // [15:0] frame_number, [47:16] transmission_count
   output logic [KIND_W-1:0]      rsp_tuser,   // [1:0] kind
   output logic                   rsp_tlast,
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   // Configuration registers.
   logic [TOTAL_W-1:0] total_ff;
   logic [WIN_W-1:0]   window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         window_ff <= WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_FRAMES: total_ff  <= TOTAL_W'(csr_wdata);
            CSR_WINDOW_SIZE:  window_ff <= csr_wdata[WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rsp_item_type          emit;
   logic                  emit_ok;
   flag_cmd_type          flag_cmd;
   logic [PTR_W-1:0]      flag_idx;
   logic [PTR_W-1:0]      rd_idx;
   logic                  rd_full;
   logic                  ram_we;
   logic [PTR_W-1:0]      ram_waddr;
   logic [FRAME_BITS-1:0] ram_wdata;
   logic [FRAME_BITS-1:0] ram_rdata;

   srsw_ctrl #(
      .WINDOW_MAX (WINDOW_MAX),
      .FRAME_BITS (FRAME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser),
      .req_ack   (req_tdata[0]),
      .total     (total_ff),
      .window    (window_ff),
      .emit_ok   (emit_ok),
      .emit      (emit),
      .flag_cmd  (flag_cmd),
      .flag_idx  (flag_idx),
      .rd_idx    (rd_idx),
      .rd_full   (rd_full),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // Occupancy of each window slot.
   srsw_flags #(
      .DEPTH (WINDOW_MAX)
   ) u_flags (
      .clock   (clock),
      .reset   (reset),
      .cmd     (flag_cmd),
      .wr_idx  (flag_idx),
      .rd_idx  (rd_idx),
      .rd_full (rd_full)
   );

   // Frame number held by each slot; its read data is used only while the slot is occupied.
   srsw_ram #(
      .WIDTH (FRAME_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   // Output register: it takes a new result whenever it is empty or being read.
   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [FRAME_W-1:0]  rsp_frame_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   assign emit_ok = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_ok) begin
         rsp_valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ok && emit.valid) begin
         rsp_kind_ff  <= emit.kind;
         rsp_frame_ff <= emit.frame;
         rsp_count_ff <= emit.count;
         rsp_last_ff  <= emit.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_frame_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> bench/srsw_checker.sv
`timescale 1ns / 1ps

// Watches the item and result channels of the sender window, keeps its own copy
// of the window state and registers, and compares every result with the oldest
// expected one.
module srsw_checker
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] acknowledged, [7:1] zero
   input  logic                  req_tuser,   // [0] func
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [47:0]           rsp_tdata,   // [15:0] frame_number, [47:16] transmission_count
   input  logic [KIND_W-1:0]     rsp_tuser,   // [1:0] kind
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    outstanding,
   output logic                  live
);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic [COUNT_W-1:0] count;
      logic               last;
   } window_result_type;

   window_result_type  expected_q[$];

   logic [TOTAL_W-1:0] total_frames;
   logic [WIN_W-1:0]   window_size;
   logic [FRAME_W-1:0] slot_frame [WINDOW_MAX];
   logic               slot_full [WINDOW_MAX];
   int                 offer_ptr;
   logic [NEXT_W-1:0]  next_frame;
   logic [COUNT_W-1:0] tx_count;
   logic               session_live;

   function automatic int slots_in_use();
      int w;
      w = int'(window_size);
      if (w == 0) w = 1;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      return w;
   endfunction

   function automatic logic [FRAME_W-1:0] frame_of(input longint unsigned n);
      longint unsigned m;
      m = (64'd1 << FRAME_BITS) - 64'd1;
      return FRAME_W'(n & m);
   endfunction

   function automatic void add_result(input logic [KIND_W-1:0] kind,
                                      input logic [FRAME_W-1:0] frame,
                                      input logic last);
      window_result_type r;
      r.kind  = kind;
      r.frame = frame;
      r.count = tx_count;
      r.last  = last;
      expected_q.push_back(r);
   endfunction

   // Moves to the next occupied slot, starting at the pointer itself, and
   // offers its frame; with every slot empty the session is over.
   function automatic void offer_next(input int ws);
      bit found;
      found = 1'b0;
      for (int k = 0; k < ws && !found; k++) begin
         if (slot_full[(offer_ptr + k) % ws]) begin
            offer_ptr = (offer_ptr + k) % ws;
            found     = 1'b1;
         end
      end
      if (found) begin
         add_result(KIND_OFFER, slot_frame[offer_ptr], 1'b1);
      end else begin
         add_result(KIND_DONE, '0, 1'b1);
         session_live = 1'b0;
      end
   endfunction

   function automatic void predict_window(input logic is_resp, input logic ack);
      int ws;
      int total;
      ws    = slots_in_use();
      total = int'(total_frames);
      if (!is_resp) begin
         for (int s = 0; s < WINDOW_MAX; s++) slot_full[s] = 1'b0;
         offer_ptr    = 0;
         tx_count     = '0;
         session_live = 1'b1;
         for (int s = 0; s < ws; s++) begin
            if (s < total) begin
               slot_frame[s] = frame_of(s);
               slot_full[s]  = 1'b1;
               add_result(KIND_SENT, slot_frame[s], 1'b0);
            end
         end
         next_frame = NEXT_W'(ws);
         offer_next(ws);
      end else if (session_live) begin
         offer_ptr = offer_ptr % ws;
         if (tx_count != COUNT_MAX) tx_count = tx_count + 1'b1;
         if (slot_full[offer_ptr] && ack) begin
            if (int'(next_frame) < total) begin
               slot_frame[offer_ptr] = frame_of(next_frame);
               add_result(KIND_SENT, slot_frame[offer_ptr], 1'b0);
            end else begin
               slot_full[offer_ptr] = 1'b0;
            end
            if (next_frame != NEXT_MAX) next_frame = next_frame + 1'b1;
         end
         offer_ptr = (offer_ptr + 1) % ws;
         offer_next(ws);
      end
   endfunction

   task automatic report_field(input string field, input longint unsigned want,
                               input longint unsigned got);
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      window_result_type want;
      window_result_type got;
      if (reset) begin
         expected_q.delete();
         mismatch_count = 0;
         total_frames   = '0;
         window_size    = WINDOW_RESET;
         for (int s = 0; s < WINDOW_MAX; s++) begin
            slot_frame[s] = '0;
            slot_full[s]  = 1'b0;
         end
         offer_ptr    = 0;
         next_frame   = '0;
         tx_count     = '0;
         session_live = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = rsp_tuser;
            got.frame = rsp_tdata[15:0];
            got.count = rsp_tdata[47:16];
            got.last  = rsp_tlast;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result kind %0d frame %0d count %0d last %0d",
                        $time, got.kind, got.frame, got.count, got.last);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.kind !== want.kind)   report_field("kind", want.kind, got.kind);
               if (got.frame !== want.frame) report_field("frame_number", want.frame, got.frame);
               if (got.count !== want.count) report_field("transmission_count", want.count,
                                                          got.count);
               if (got.last !== want.last)   report_field("last", want.last, got.last);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TOTAL_FRAMES: total_frames = csr_wdata[TOTAL_W-1:0];
               CSR_WINDOW_SIZE:  window_size  = csr_wdata[WIN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_window(req_tuser, req_tdata[0]);
      end
      outstanding = expected_q.size();
      live        = session_live;
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the selective-repeat sender window. All result checking
// is done by the checker beside the block; this module drives items, the
// configuration registers and the result-side stalls, and watches for a hang.
module tb_top
   import srsw_pkg::*;
();

   // Cycles in which nothing moves before the run is declared hung.
   localparam int IDLE_LIMIT    = 4000;
   // Settling time after the last expected result; it covers a start into 16 slots plus a full search.
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS  = 130;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [0] acknowledged, [7:1] zero
   logic                  req_tuser;   // [0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;   // [15:0] frame_number, [47:16] transmission_count
   logic [KIND_W-1:0]     rsp_tuser;   // [1:0] kind
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   mismatch_count;
   int   outstanding;
   logic live;

   int   burst_left;
   int   counted_items;
   int   quiet_cycles = 0;
   int   stall_tick   = 0;
   int   stall_mode   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   selective_repeat_sender_window u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   srsw_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .live           (live)
   );

   // The result side draws its own stall modes at random: always ready, a
   // regular one-in-three stall, coin flips, and long stalls. The mode is redrawn
   // periodically so that each one meets every phase of the block's work.
   always @(negedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= (stall_tick % 3 != 0);
         2:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_tick % 16 >= 10);
      endcase
   end

   // Hang detection: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("selective_repeat_sender_window: mismatch");
            $finish;
         end
      end
   end

   // Offers one item and returns at the falling edge after it is taken. The
   // sender works in bursts: while a burst lasts, valid stays high into the
   // next item; at the end of a burst it drops for a random gap. An item only
   // counts when the block acts on it, which is any start and any response
   // while a session is open.
   task automatic send_item(input logic is_resp, input logic ack);
      if (!is_resp || live) counted_items++;
      req_tvalid <= 1'b1;
      req_tuser  <= is_resp;
      req_tdata  <= {7'b0, ack};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Brings the block to rest: no item offered, every expected result seen,
   // and then enough cycles for any work that produces no result to finish.
   task automatic quiesce();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // The window register only keeps its low five bits, so the bits above it
   // carry random junk that the block must ignore.
   task automatic write_window(input int slots);
      write_reg(CSR_WINDOW_SIZE, {11'($urandom), 5'(slots)});
   endtask

   task automatic configure(input int total, input int slots);
      write_reg(CSR_TOTAL_FRAMES, 16'(total));
      write_window(slots);
   endtask

   // One random session. Totals are mostly small so that sessions run to
   // completion; a few use zero, one or a huge total. Window sizes cover the
   // zero and oversize encodings as well as the full window.
   task automatic run_session();
      int total;
      int slots;
      int budget;
      case ($urandom_range(0, 9))
         0:       total = 0;
         1:       total = 1;
         2:       total = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(100, 65535);
         default: total = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 7))
         0:       slots = 0;
         1:       slots = $urandom_range(17, 31);
         2:       slots = 16;
         default: slots = $urandom_range(1, 15);
      endcase
      quiesce();
      configure(total, slots);
      send_item(1'b0, 1'($urandom));
      budget = $urandom_range(20, 70);
      while (live && budget > 0 && counted_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 59))
            0: begin
               // Resize the window in the middle of a session.
               quiesce();
               write_window($urandom_range(0, 31));
            end
            1: send_item(1'b0, 1'($urandom));   // restart from scratch
            default: send_item(1'b1, ($urandom_range(0, 9) < 7));
         endcase
         budget--;
      end
      // A little noise: responses that usually find the session closed.
      repeat ($urandom_range(0, 2)) send_item(1'b1, 1'($urandom));
   endtask

   initial begin
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_TOTAL_FRAMES;
      csr_wdata     = '0;
      burst_left    = 0;
      counted_items = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A response before any session has been opened is dropped.
      send_item(1'b1, 1'b1);
      // With the reset registers (no frames, four slots) a start reports done
      // as its only result, with a count of zero.
      send_item(1'b0, 1'b0);

      // Fewer frames than slots, with an oversize window that clamps to the
      // full window: the unfilled slots start empty. A lost frame is retried,
      // acknowledged frames drain the window, and the response after done is
      // dropped.
      quiesce();
      configure(3, 31);
      send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);

      // Largest total with a zero window, which acts as one slot; a start in
      // the middle of the session restarts it.
      quiesce();
      configure(65535, 0);
      send_item(1'b0, 1'b0);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b1);

      // Shrink the window below the offer pointer during a session, then grow
      // it to the full window so that the untouched slots are skipped.
      quiesce();
      configure(20, 5);
      send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);
      quiesce();
      write_window(2);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);
      quiesce();
      write_window(16);
      send_item(1'b1, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);

      while (counted_items < RANDOM_ITEMS) run_session();

      quiesce();
      if (mismatch_count == 0) begin
         $display("selective_repeat_sender_window: match");
      end else begin
         $display("selective_repeat_sender_window: mismatch");
      end
      $finish;
   end

endmodule
